// ===== rtl/core/key_scan_event_generator_assert.svh =====
// Assertion macros for the key scan event generator.
// Each check is sampled on the rising edge of clk and is idle while rst_n is low.
`ifndef KEY_SCAN_EVENT_GENERATOR_ASSERT_SVH
`define KEY_SCAN_EVENT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define KSEG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kseg: same-cycle check failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define KSEG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kseg: next-cycle check failed");
`else
`define KSEG_ASSERT_IMP(label, ante, cons)
`define KSEG_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/kseg_pkg.sv =====
`default_nettype none

package kseg_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIDI_CHANNEL  = 3'd0;
    localparam logic [2:0] CFG_OFFLINE_TEST  = 3'd1;
    localparam logic [2:0] CFG_STRIP_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_REPEAT_DELAY  = 3'd3;
    localparam logic [2:0] CFG_REPEAT_PERIOD = 3'd4;

    localparam logic [31:0] RESET_DELAY_US  = 32'd2000000;
    localparam logic [31:0] RESET_PERIOD_US = 32'd333000;

    localparam logic EVENT_NOTE_ON  = 1'b0;
    localparam logic EVENT_NOTE_OFF = 1'b1;

    localparam logic [1:0] STRIP_NONE = 2'd0;
    localparam logic [1:0] STRIP_ON   = 2'd1;
    localparam logic [1:0] STRIP_OFF  = 2'd2;

    typedef struct packed {
        logic       event_kind;
        logic       is_repeat;
        logic [6:0] note_number;
        logic [3:0] channel;
        logic       led_write;
        logic       led_value;
        logic [1:0] strip_action;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/kseg_ram.sv =====
`default_nettype none

module kseg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_scan_event_generator.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  key sample: index, pressed, scan time
// m_*       out        m_tvalid / m_tready  note event, LED and strip flags
// cfg_*     in         cfg_we               register index and data, write only
//
// One key sample is taken every cycle while s_tready is high; its event, if
// any, goes from the input register to the output register. The stamp memory
// is read at the accepting edge alongside the input register; a write to the
// key being read in the same cycle is bypassed. Reset clears held flags, shift
// state and registers at once; stamps need no clearing. A stalled output holds
// the decision stage, and the input then stalls only while both are full.
`default_nettype none
`include "key_scan_event_generator_assert.svh"

module key_scan_event_generator
    import kseg_pkg::*;
#(
    parameter int NUM_KEYS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] key_index, [6] key_pressed, [38:7] scan_time_us, [39] zero
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] note_number, [10:7] channel, [11] led_write, [12] led_value,
    // [14:13] strip_action, [15] zero
    output logic      [15:0] m_tdata,
    // [0] event_kind, [1] is_repeat
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int KEY_W = $clog2(NUM_KEYS);

    // configuration
    logic [3:0]  channel_reg;
    logic        offline_reg;
    logic        strip_en_reg;
    logic [31:0] delay_reg;
    logic [31:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg  <= '0;
            offline_reg  <= 1'b1;
            strip_en_reg <= 1'b0;
            delay_reg    <= RESET_DELAY_US;
            period_reg   <= RESET_PERIOD_US;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIDI_CHANNEL:  channel_reg  <= cfg_data[3:0];
                CFG_OFFLINE_TEST:  offline_reg  <= cfg_data[0];
                CFG_STRIP_ENABLE:  strip_en_reg <= cfg_data[0];
                CFG_REPEAT_DELAY:  delay_reg    <= cfg_data;
                CFG_REPEAT_PERIOD: period_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes
    logic    s1_valid_reg;
    logic    s1_adv;
    logic    in_accept;
    logic    out_free;
    logic    m_valid_reg;
    result_t out_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;

    // decision stage input register
    logic [5:0]  s1_key_reg;
    logic        s1_pressed_reg;
    logic [31:0] s1_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_key_reg     <= s_tdata[5:0];
            s1_pressed_reg <= s_tdata[6];
            s1_time_reg    <= s_tdata[38:7];
        end
    end

    // stamp memory with write bypass
    logic             stamp_we;
    logic [31:0]      stamp_wdata;
    logic [31:0]      ram_rdata;
    logic [KEY_W-1:0] s1_addr;
    logic [KEY_W-1:0] in_addr;
    logic             fwd_valid_reg;
    logic [31:0]      fwd_data_reg;
    logic             stamp_write;

    assign s1_addr     = s1_key_reg[KEY_W-1:0];
    assign in_addr     = s_tdata[KEY_W-1:0];
    assign stamp_write = s1_adv && stamp_we;

    kseg_ram #(
        .WIDTH (32),
        .DEPTH (NUM_KEYS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_write),
        .waddr (s1_addr),
        .wdata (stamp_wdata),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // drop the bypass whenever the decision stage empties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            fwd_valid_reg <= s_tvalid && stamp_write && (s1_addr == in_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_data_reg <= stamp_wdata;
        end
    end

    // per-key and shift state
    logic [NUM_KEYS-1:0] key_held_reg;
    logic                shift_now_reg;
    logic                shift_before_reg;

    // decision logic
    logic        in_range;
    logic        is_key0;
    logic        was_held;
    logic [31:0] stamp;
    logic [31:0] elapsed;
    logic        due;
    logic [6:0]  note_plain;
    logic [6:0]  note_shift;
    logic        held_we;
    logic        held_val;
    logic        res_valid;
    result_t     res;

    assign in_range   = {1'b0, s1_key_reg} < 7'(NUM_KEYS);
    assign is_key0    = (s1_key_reg == '0);
    assign was_held   = key_held_reg[s1_addr];
    assign stamp      = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign elapsed    = s1_time_reg - stamp;
    assign due        = elapsed > delay_reg;
    assign note_plain = {1'b0, s1_key_reg};
    assign note_shift = note_plain + 7'(NUM_KEYS);

    always_comb
    begin
        res_valid        = 1'b0;
        held_we          = 1'b0;
        held_val         = 1'b0;
        stamp_we         = 1'b0;
        stamp_wdata      = s1_time_reg;
        res.event_kind   = EVENT_NOTE_ON;
        res.is_repeat    = 1'b0;
        res.note_number  = note_plain;
        res.channel      = channel_reg;
        res.led_write    = 1'b0;
        res.led_value    = 1'b0;
        res.strip_action = STRIP_NONE;
        if (in_range)
        begin
            if (s1_pressed_reg)
            begin
                if (!is_key0 && (shift_now_reg || shift_before_reg))
                begin
                    res.note_number = note_shift;
                end
                if (!was_held)
                begin
                    res_valid     = 1'b1;
                    held_we       = 1'b1;
                    held_val      = 1'b1;
                    stamp_we      = 1'b1;
                    res.led_write = offline_reg;
                    res.led_value = offline_reg;
                    if (is_key0 && strip_en_reg)
                    begin
                        res.strip_action = STRIP_ON;
                    end
                end
                else if (!is_key0 && due)
                begin
                    res_valid     = 1'b1;
                    stamp_we      = 1'b1;
                    stamp_wdata   = stamp + period_reg;
                    res.is_repeat = 1'b1;
                end
            end
            else if (was_held)
            begin
                res_valid      = 1'b1;
                held_we        = 1'b1;
                res.event_kind = EVENT_NOTE_OFF;
                res.led_write  = offline_reg;
                if (!is_key0 && shift_now_reg)
                begin
                    res.note_number = note_shift;
                end
                if (is_key0 && strip_en_reg)
                begin
                    res.strip_action = STRIP_OFF;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_held_reg     <= '0;
            shift_now_reg    <= 1'b0;
            shift_before_reg <= 1'b0;
        end
        else if (s1_adv && in_range)
        begin
            if (held_we)
            begin
                key_held_reg[s1_addr] <= held_val;
            end
            // key 0 samples track the shift state
            if (is_key0)
            begin
                shift_before_reg <= was_held;
                shift_now_reg    <= s1_pressed_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            m_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.strip_action, out_reg.led_value, out_reg.led_write,
                       out_reg.channel, out_reg.note_number};
    assign m_tuser  = {out_reg.is_repeat, out_reg.event_kind};

    `KSEG_ASSERT_IMP(a_repeat_quiet, m_valid_reg && out_reg.is_repeat,
        !out_reg.led_write && (out_reg.strip_action == STRIP_NONE) &&
        (out_reg.event_kind == EVENT_NOTE_ON))
    `KSEG_ASSERT_IMP(a_key0_no_repeat, m_valid_reg && (out_reg.note_number == '0),
        !out_reg.is_repeat)
    `KSEG_ASSERT_IMP(a_fwd_has_item, fwd_valid_reg, s1_valid_reg)
    `KSEG_ASSERT_NXT(a_press_sets_held,
        s1_adv && res_valid && !res.is_repeat && (res.event_kind == EVENT_NOTE_ON),
        key_held_reg[$past(s1_addr)])

endmodule

`default_nettype wire
